[rtl/bda_pkg.sv]
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants of the descriptor bitmap allocator
// Request codes, status codes, controller states and the port bundle between
// the controller and the bitmap memory.
// ----------------------------------------------------------------------------
package bda_pkg;

   localparam int BITMAP_BYTES_DEF = 1024;
   localparam int BYTES_W = 11;
   localparam int FREE_W = 14;
   localparam int NUM_W = 13;
   localparam int IDX_W = 10;
   localparam logic [31:0] LCG_MUL = 32'd1103515245;
   localparam logic [31:0] LCG_ADD = 32'd12345;
   localparam logic [7:0] BYTE_FULL = 8'hff;
   localparam logic [7:0] BIT_TOP = 8'h80;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE = 2'd1;
   localparam logic [1:0] REQ_LOAD = 2'd2;
   localparam logic [1:0] REQ_READ = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic CSR_BYTES = 1'b0;
   localparam logic CSR_FREE = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MUL, S_MOD, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK,
      S_RMW_RD, S_RMW_WR, S_RESP
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic [15:0] addr;
      logic [7:0] wdata;
   } mem_req_type;

endpackage

[rtl/bda_bitmap_mem.sv]
// ----------------------------------------------------------------------------
// bda_bitmap_mem: bitmap storage
// Single-port synchronous RAM, one byte per entry, registered read data.
// ----------------------------------------------------------------------------
module bda_bitmap_mem
   import bda_pkg::*;
#(
   parameter int BITMAP_BYTES = BITMAP_BYTES_DEF,
   localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1
) (
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rdata
);
   logic [7:0] mem [BITMAP_BYTES];
   logic [AW-1:0] a;
   assign a = mem_req.addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[a] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rdata <= mem[a];
      end
   end
endmodule

[rtl/bitmap_descriptor_allocator_top.sv]
// ----------------------------------------------------------------------------
// bitmap_descriptor_allocator_top: next-fit descriptor allocator
// Allocate, free, load and read requests over a byte-wide allocation bitmap.
// ----------------------------------------------------------------------------
// req_ channel: one request word; rsp_ channel: one result word per request.
// csr_ channel: index 0 bytes in use, 1 start free count (also reloads the
// counter). Requests are handled one at a time.
// Free, load and read go through dispatch and a read of the addressed byte;
// free and load then write the new byte back through the single RAM port.
// A hinted allocate reads and checks bitmap bytes from the hint on, then
// sets the first clear bit of the first byte that is not full. A random
// start first runs a multiply step, then the bit-serial remainder (one quotient bit per cycle).
// After reset the RAM is cleared one byte per cycle;
// requests are not taken during that pass, csr writes are.
// The result sits in an output register; while rsp_ready is low the block
// holds it and takes no new request.
// ----------------------------------------------------------------------------
module bitmap_descriptor_allocator_top
   import bda_pkg::*;
#(
   parameter int BITMAP_BYTES = BITMAP_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic               req_hint_valid,
   input  logic [NUM_W-1:0]   req_hint_number,
   input  logic [31:0]        req_time_seconds,
   input  logic [NUM_W-1:0]   req_release_number,
   input  logic [IDX_W-1:0]   req_byte_index,
   input  logic [7:0]         req_load_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [NUM_W-1:0]   rsp_granted_number,
   output logic [7:0]         rsp_read_value,
   output logic [FREE_W-1:0]  rsp_free_left,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [FREE_W-1:0]  csr_data
);
   localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
   localparam int FMX = (BITMAP_BYTES * 8 > 16383) ? 16383 : BITMAP_BYTES * 8;
   localparam logic [FREE_W-1:0] FREE_MAX = FREE_W'(FMX);
   localparam logic [16:0] BB = 17'(BITMAP_BYTES);

   state_type state_ff, state_in;
   logic [BYTES_W-1:0] bytes_ff;
   logic [FREE_W-1:0] free_ff, free_in;
   logic [1:0] type_ff;
   logic hv_ff;
   logic [NUM_W-1:0] hint_ff, rel_ff;
   logic [IDX_W-1:0] bidx_ff;
   logic [7:0] load_ff;
   logic [31:0] time_ff;
   logic [31:0] rem_ff;       // remainder of the LCG value modulo the bytes in use
   logic [30:0] rnd_ff;
   logic [5:0] cnt_ff;
   logic [16:0] pos_ff, left_ff, clr_ff;
   logic [7:0] byte_ff;
   logic rsp_valid_ff;
   logic [1:0] st_ff;
   logic [NUM_W-1:0] gr_ff;
   logic [7:0] rv_ff;
   logic [7:0] rdata;
   mem_req_type mem_req;

   logic [16:0] nact;
   always_comb begin
      if (bytes_ff == '0) nact = 17'd1;
      else if (17'(bytes_ff) > BB) nact = BB;
      else nact = 17'(bytes_ff);
   end

   // first clear bit, msb first
   logic [2:0] fbit;
   always_comb begin
      fbit = 3'd7;
      for (int k = 7; k >= 0; k--) begin
         if (!byte_ff[7-k]) fbit = 3'(k);
      end
   end

   logic [32:0] rtrial;
   assign rtrial = {rem_ff, rnd_ff[30]} - 33'(nact);

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = st_ff;
   assign rsp_granted_number = gr_ff;
   assign rsp_read_value = rv_ff;
   assign rsp_free_left = free_ff;

   logic acc;
   assign acc = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == BB - 17'd1) state_in = S_IDLE;
         S_IDLE: if (acc) state_in = (req_type == REQ_ALLOC && !req_hint_valid) ?
                                     S_MUL : S_DISPATCH;
         S_MUL: state_in = S_MOD;
         S_MOD: if (cnt_ff == 6'd30) state_in = S_DISPATCH;
         S_DISPATCH: begin
            priority case (type_ff)
               REQ_ALLOC: state_in = (17'(hint_ff[NUM_W-1:3]) >= nact && hv_ff) ?
                                     S_RESP : S_SCAN_RD;
               REQ_FREE: state_in = (17'(rel_ff[NUM_W-1:3]) >= nact) ? S_RESP : S_RMW_RD;
               default: state_in = (17'(bidx_ff) >= BB) ? S_RESP : S_RMW_RD;
            endcase
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (rdata != BYTE_FULL) state_in = S_RMW_WR;
            else if (left_ff == 17'd1) state_in = S_RESP;
            else state_in = S_SCAN_RD;
         end
         S_RMW_RD: state_in = S_RMW_WR;
         S_RMW_WR: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // memory port
   always_comb begin
      mem_req = '0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_req.wr_en = 1'b1;
            mem_req.addr = 16'(clr_ff);
         end
         S_SCAN_RD: begin
            mem_req.rd_en = 1'b1;
            mem_req.addr = 16'(pos_ff);
         end
         S_RMW_RD: begin
            mem_req.rd_en = 1'b1;
            mem_req.addr = 16'(pos_ff);
         end
         S_RMW_WR: begin
            mem_req.addr = 16'(pos_ff);
            priority case (type_ff)
               REQ_ALLOC: begin
                  mem_req.wr_en = 1'b1;
                  mem_req.wdata = byte_ff | (BIT_TOP >> fbit);
               end
               REQ_FREE: begin
                  mem_req.wr_en = 1'b1;
                  mem_req.wdata = rdata & ~(BIT_TOP >> rel_ff[2:0]);
               end
               REQ_LOAD: begin
                  mem_req.wr_en = 1'b1;
                  mem_req.wdata = load_ff;
               end
               default: mem_req.wr_en = 1'b0;
            endcase
         end
         default: mem_req = '0;
      endcase
   end

   bda_bitmap_mem #(.BITMAP_BYTES(BITMAP_BYTES)) u_mem (
      .clock(clock), .mem_req(mem_req), .rdata(rdata)
   );

   always_comb begin
      free_in = free_ff;
      if (csr_valid && csr_index == CSR_FREE)
         free_in = (csr_data > FREE_MAX) ? FREE_MAX : csr_data;
      else if (state_ff == S_RMW_WR && type_ff == REQ_ALLOC && free_ff != '0)
         free_in = free_ff - 1'b1;
      else if (state_ff == S_RMW_WR && type_ff == REQ_FREE && free_ff < FREE_MAX)
         free_in = free_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         bytes_ff <= BYTES_W'(1024);
         free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_ff <= free_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 17'd1;
         if (csr_valid && csr_index == CSR_BYTES) bytes_ff <= csr_data[BYTES_W-1:0];
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_RESP) rsp_valid_ff <= 1'b1;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: if (acc) begin
            type_ff <= req_type;
            hv_ff <= req_hint_valid;
            hint_ff <= req_hint_number;
            rel_ff <= req_release_number;
            bidx_ff <= req_byte_index;
            load_ff <= req_load_value;
            time_ff <= req_time_seconds;
            st_ff <= ST_OK;
            gr_ff <= '0;
            rv_ff <= '0;
         end
         S_MUL: begin
            rnd_ff <= 31'(time_ff * LCG_MUL + LCG_ADD);
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         S_MOD: begin
            if (!rtrial[32]) rem_ff <= rtrial[31:0];
            else rem_ff <= {rem_ff[30:0], rnd_ff[30]};
            rnd_ff <= {rnd_ff[29:0], 1'b0};
            cnt_ff <= cnt_ff + 6'd1;
         end
         S_DISPATCH: begin
            left_ff <= nact;
            priority case (type_ff)
               REQ_ALLOC: begin
                  pos_ff <= hv_ff ? 17'(hint_ff[NUM_W-1:3]) : rem_ff[16:0];
                  if (hv_ff && 17'(hint_ff[NUM_W-1:3]) >= nact) st_ff <= ST_RANGE;
               end
               REQ_FREE: begin
                  pos_ff <= 17'(rel_ff[NUM_W-1:3]);
                  if (17'(rel_ff[NUM_W-1:3]) >= nact) st_ff <= ST_RANGE;
               end
               default: begin
                  pos_ff <= 17'(bidx_ff);
                  if (17'(bidx_ff) >= BB) st_ff <= ST_RANGE;
               end
            endcase
         end
         S_SCAN_CHK: begin
            byte_ff <= rdata;
            if (rdata == BYTE_FULL) begin
               left_ff <= left_ff - 17'd1;
               pos_ff <= (pos_ff + 17'd1 == nact) ? '0 : pos_ff + 17'd1;
               if (left_ff == 17'd1) st_ff <= ST_FULL;
            end
         end
         S_RMW_RD: ;
         S_RMW_WR: begin
            if (type_ff == REQ_ALLOC) gr_ff <= NUM_W'({pos_ff, fbit});
            if (type_ff == REQ_READ) rv_ff <= rdata;
            if (type_ff == REQ_FREE || type_ff == REQ_LOAD) byte_ff <= rdata;
         end
         default: ;
      endcase
      if (state_ff == S_RMW_RD) byte_ff <= rdata;
   end

   property p_no_req_when_busy;
      @(posedge clock) disable iff (reset) rsp_valid_ff |-> !req_ready;
   endproperty
   a_no_req_when_busy: assert property (p_no_req_when_busy) else $error("busy accept");

   property p_free_bound;
      @(posedge clock) disable iff (reset) free_ff <= FREE_MAX;
   endproperty
   a_free_bound: assert property (p_free_bound) else $error("free count overflow");

   property p_resp_follows;
      @(posedge clock) disable iff (reset) state_ff == S_RESP |=> rsp_valid_ff;
   endproperty
   a_resp_follows: assert property (p_resp_follows) else $error("result lost");
endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of bitmap_descriptor_allocator_top
// Drives allocate, free, load and read words under several register settings.
// A scoreboard keeps its own bitmap and free count, predicts every result
// word and checks each one against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import bda_pkg::*;

   localparam int MAP_BYTES = 1024;
   localparam int COUNT_MAX = 8192;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [1:0]        status;
      logic [NUM_W-1:0]  granted;
      logic [7:0]        rd_value;
      logic [FREE_W-1:0] free_left;
   } alloc_result_type;

   class alloc_scoreboard;
      logic [7:0]    bitmap [MAP_BYTES];
      int unsigned   bytes_reg;
      int unsigned   free_cnt;
      alloc_result_type pending_q[$];
      int            errors;
      int            checked;

      function new();
         foreach (bitmap[i]) bitmap[i] = 8'h00;
         bytes_reg = 1024;
         free_cnt = 0;
         errors = 0;
         checked = 0;
      endfunction

      function int unsigned live_bytes();
         if (bytes_reg == 0) return 1;
         if (bytes_reg > MAP_BYTES) return MAP_BYTES;
         return bytes_reg;
      endfunction

      function void write_reg(logic idx, logic [FREE_W-1:0] data);
         if (idx == CSR_BYTES) bytes_reg = data & 14'h7ff;
         else free_cnt = (data > COUNT_MAX) ? COUNT_MAX : data;
      endfunction

      // predict the result of one accepted request word
      function void note_request(logic [1:0] kind, logic hint_ok, logic [NUM_W-1:0] hint,
                                 logic [31:0] secs, logic [NUM_W-1:0] rel,
                                 logic [IDX_W-1:0] idx, logic [7:0] value);
         alloc_result_type res;
         int unsigned   n, start, pos, bitpos;
         logic [31:0]   seed;
         bit            found;
         n = live_bytes();
         res = '{ST_OK, '0, '0, '0};
         case (kind)
            REQ_ALLOC: begin
               if (hint_ok) begin
                  start = hint >> 3;
               end else begin
                  seed = secs * LCG_MUL + LCG_ADD;
                  start = (seed & 32'h7fffffff) % n;
               end
               if (start >= n) begin
                  res.status = ST_RANGE;
               end else begin
                  found = 0;
                  pos = start;
                  for (int k = 0; k < n; k++) begin
                     if (bitmap[pos] != BYTE_FULL) begin
                        found = 1;
                        break;
                     end
                     pos = (pos + 1 == n) ? 0 : pos + 1;
                  end
                  if (!found) begin
                     res.status = ST_FULL;
                  end else begin
                     bitpos = 0;
                     while (bitpos < 7 && bitmap[pos][7-bitpos]) bitpos++;
                     bitmap[pos][7-bitpos] = 1'b1;
                     res.granted = NUM_W'(pos * 8 + bitpos);
                     if (free_cnt > 0) free_cnt--;
                  end
               end
            end
            REQ_FREE: begin
               if ((rel >> 3) >= n) begin
                  res.status = ST_RANGE;
               end else begin
                  bitmap[rel >> 3][7 - rel[2:0]] = 1'b0;
                  if (free_cnt < COUNT_MAX) free_cnt++;
               end
            end
            REQ_LOAD: bitmap[idx] = value;
            default: res.rd_value = bitmap[idx];
         endcase
         res.free_left = FREE_W'(free_cnt);
         pending_q.push_back(res);
      endfunction

      function void check_result(logic [1:0] st, logic [NUM_W-1:0] gr, logic [7:0] rv,
                                 logic [FREE_W-1:0] fl);
         alloc_result_type e;
         checked++;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result word status=%0d granted=%0d", $time, st, gr);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
         end
         if (gr !== e.granted) begin
            $display("%0t: granted expected %0d actual %0d", $time, e.granted, gr);
            errors++;
         end
         if (rv !== e.rd_value) begin
            $display("%0t: read_value expected %0h actual %0h", $time, e.rd_value, rv);
            errors++;
         end
         if (fl !== e.free_left) begin
            $display("%0t: free_left expected %0d actual %0d", $time, e.free_left, fl);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [1:0]        req_type = REQ_READ;
   logic              req_hint_valid = 0;
   logic [NUM_W-1:0]  req_hint_number = '0;
   logic [31:0]       req_time_seconds = '0;
   logic [NUM_W-1:0]  req_release_number = '0;
   logic [IDX_W-1:0]  req_byte_index = '0;
   logic [7:0]        req_load_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [1:0]        rsp_status;
   logic [NUM_W-1:0]  rsp_granted_number;
   logic [7:0]        rsp_read_value;
   logic [FREE_W-1:0] rsp_free_left;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic              csr_index = CSR_BYTES;
   logic [FREE_W-1:0] csr_data = '0;

   alloc_scoreboard sb = new();
   bit   quiet = 0;
   int   accepted = 0;
   int   cycles = 0;
   int unsigned cur_bytes = 1024;

   bitmap_descriptor_allocator_top u_top (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL bitmap_descriptor_allocator_top");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready)
            sb.note_request(req_type, req_hint_valid, req_hint_number, req_time_seconds,
                            req_release_number, req_byte_index, req_load_value);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_status, rsp_granted_number, rsp_read_value, rsp_free_left);
      end
   end

   // result side stalls in bursts
   initial begin
      @(posedge clock);
      forever begin
         rsp_ready <= 1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!quiet) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic [1:0] kind, logic hint_ok, logic [NUM_W-1:0] hint,
                            logic [31:0] secs, logic [NUM_W-1:0] rel,
                            logic [IDX_W-1:0] idx, logic [7:0] value);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= kind;
      req_hint_valid <= hint_ok;
      req_hint_number <= hint;
      req_time_seconds <= secs;
      req_release_number <= rel;
      req_byte_index <= idx;
      req_load_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted++;
   endtask

   task automatic write_csr(logic idx, logic [FREE_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      if (idx == CSR_BYTES) cur_bytes = data & 14'h7ff;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.checked != accepted) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // mostly in-range allocate/free with random content, some noise
   task automatic random_word();
      int unsigned n, pick, top;
      logic [NUM_W-1:0] num;
      logic [IDX_W-1:0] idx;
      logic [7:0] val;
      n = (cur_bytes == 0) ? 1 : (cur_bytes > MAP_BYTES ? MAP_BYTES : cur_bytes);
      top = n * 8 - 1;
      num = ($urandom_range(0, 9) == 0) ? NUM_W'($urandom_range(0, 8191)) :
                                          NUM_W'($urandom_range(0, top));
      idx = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(0, 1023)) :
                                          IDX_W'($urandom_range(0, n - 1));
      pick = $urandom_range(0, 2);
      val = (pick == 0) ? BYTE_FULL : (pick == 1) ? 8'h00 : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45)
         send_word(REQ_ALLOC, 1'($urandom_range(0, 1)), num, $urandom, NUM_W'($urandom),
                   idx, val);
      else if (pick < 75)
         send_word(REQ_FREE, 1'($urandom_range(0, 1)), NUM_W'($urandom), $urandom, num,
                   idx, val);
      else if (pick < 85)
         send_word(REQ_LOAD, 1'($urandom_range(0, 1)), NUM_W'($urandom), $urandom,
                   NUM_W'($urandom), idx, val);
      else
         send_word(REQ_READ, 1'($urandom_range(0, 1)), NUM_W'($urandom), $urandom,
                   NUM_W'($urandom), idx, val);
   endtask

   initial begin
      int unsigned bytes_set[7] = '{16, 0, 2047, 1024, 1, 64, 3};
      int unsigned free_set[7] = '{100, 16383, 0, 8192, 0, 300, 5};
      repeat (7) @(posedge clock);
      reset <= 0;
      // directed part: 4 bytes in use, counter starts at 0
      write_csr(CSR_BYTES, 4);
      write_csr(CSR_FREE, 0);
      send_word(REQ_READ, 0, 0, 0, 0, 0, 0);
      send_word(REQ_LOAD, 0, 0, 0, 0, 0, BYTE_FULL);
      send_word(REQ_ALLOC, 1, 0, 0, 0, 0, 0);          // skips full byte, counter at 0
      send_word(REQ_ALLOC, 1, 31, 0, 0, 0, 0);
      send_word(REQ_FREE, 0, 0, 0, 8, 0, 0);
      send_word(REQ_FREE, 0, 0, 0, 8, 0, 0);           // already free
      send_word(REQ_FREE, 0, 0, 0, 32, 0, 0);          // out of range
      send_word(REQ_FREE, 0, 0, 0, 13'h1fff, 0, 0);
      send_word(REQ_ALLOC, 1, 32, 0, 0, 0, 0);         // hint out of range
      send_word(REQ_ALLOC, 1, 13'h1fff, 0, 0, 0, 0);
      for (int b = 1; b < 4; b++) send_word(REQ_LOAD, 0, 0, 0, 0, IDX_W'(b), BYTE_FULL);
      send_word(REQ_ALLOC, 0, 0, 0, 0, 0, 0);          // bitmap full
      send_word(REQ_LOAD, 0, 0, 0, 0, 10'h3ff, 8'h55); // above bytes in use
      send_word(REQ_READ, 0, 0, 0, 0, 10'h3ff, 0);
      send_word(REQ_LOAD, 0, 0, 0, 0, 2, 8'hfe);
      send_word(REQ_ALLOC, 0, 0, 32'hffffffff, 0, 0, 0);
      send_word(REQ_LOAD, 0, 0, 0, 0, 2, 8'h00);
      send_word(REQ_ALLOC, 0, 0, 32'h0, 0, 0, 0);
      send_word(REQ_READ, 0, 0, 0, 0, 2, 0);
      for (int p = 0; p < 7; p++) begin
         drain();
         write_csr(CSR_BYTES, FREE_W'(bytes_set[p]));
         write_csr(CSR_FREE, FREE_W'(free_set[p]));
         quiet = (p == 6);
         for (int i = 0; i < 78; i++) random_word();
      end
      drain();
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("PASS bitmap_descriptor_allocator_top");
      else
         $display("FAIL bitmap_descriptor_allocator_top");
      $finish;
   end

endmodule
